// ===== rtl/ter_pkg.sv =====
// ----------------------------------------------------------------------------
// ter_pkg
// Types, codes and widths shared by the triangle edge rasterizer modules.
// ----------------------------------------------------------------------------
package ter_pkg;

  localparam int CoordIntBits  = 12;
  localparam int CoordFracBits = 4;
  localparam int CoordW        = CoordIntBits + CoordFracBits;
  localparam int ScanW         = CoordIntBits + 1;        // one bit past a pixel coordinate
  localparam int PtW           = CoordW + 2;              // fixed-point sample point
  localparam int DiffW         = CoordW + 1;              // vertex difference
  localparam int RelW          = PtW + 1;                 // point minus vertex
  localparam int ProdW         = DiffW + RelW;
  localparam int EdgeW         = ProdW + 1;
  localparam int SumW          = EdgeW + 10;              // three 8-bit weighted terms
  localparam int LightW        = 9;
  localparam int ScaledW       = SumW + LightW;
  localparam int QuotW         = 17;
  localparam int DivW          = EdgeW + QuotW - 1;
  localparam int QueueDepth    = 2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ACC,
    F_CHK
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUM,
    B_SCALE,
    B_DIV
  } back_state_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        vertex_index;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [7:0]        vertex_red;
    logic [7:0]        vertex_green;
    logic [7:0]        vertex_blue;
    logic [8:0]        light;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [11:0] px;
    logic signed [11:0] py;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } res_t;

  // work handed from the front end to the shading back end
  typedef struct packed {
    kind_e              kind;
    logic [11:0]        px;
    logic [11:0]        py;
    logic [EdgeW-1:0]   w0;
    logic [EdgeW-1:0]   w1;
    logic [EdgeW-1:0]   w2;
    logic [EdgeW-1:0]   den;
    logic [LightW-1:0]  light;
    logic [23:0]        rgb0;
    logic [23:0]        rgb1;
    logic [23:0]        rgb2;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/ter_queue.sv =====
// ----------------------------------------------------------------------------
// ter_queue
// Short FIFO of jobs between the edge front end and the shading back end.
// ----------------------------------------------------------------------------
module ter_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ter_pkg::job_t push_data_i,
  input  logic          pop_i,
  output ter_pkg::job_t pop_data_o,
  output ter_pkg::q_status_t status_o
);
  import ter_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  job_t                 mem_q [QueueDepth];
  logic [PtrW-1:0]      wr_q, rd_q;
  logic [PtrW:0]        cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  assign pop_data_o      = mem_q[rd_q];
  assign status_o.full   = (cnt_q == (PtrW+1)'(QueueDepth));
  assign status_o.empty  = (cnt_q == '0);

endmodule

// ===== rtl/ter_front.sv =====
// ----------------------------------------------------------------------------
// ter_front
// Decodes words, holds the vertices, sets up the box and walks the scan,
// each edge function taking a multiply step and an accumulate step.
// ----------------------------------------------------------------------------
module ter_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  ter_pkg::in_t  in_i,
  output logic          idle_o,
  output logic          push_o,
  output ter_pkg::job_t job_o
);
  import ter_pkg::*;

  front_state_e            state_q, state_d;
  logic signed [CoordW-1:0] cx_q [3];
  logic signed [CoordW-1:0] cy_q [3];
  logic [23:0]             crgb_q [3];
  logic [LightW-1:0]       light_q;
  logic signed [EdgeW-1:0] area_q;
  logic signed [CoordW-1:0] bminx_q, bmaxx_q, bmaxy_q;
  logic signed [ScanW-1:0] sx_q, sy_q;
  logic                    row_in_q, active_q, start_mode_q;
  logic [1:0]              e_q;
  logic signed [ProdW-1:0] p1_q, p2_q;
  logic signed [EdgeW-1:0] edge_q [3];

  logic signed [CoordW-1:0] xi, yi, xj, yj;
  logic signed [PtW-1:0]    ptx, pty;
  logic signed [DiffW-1:0]  dx, dy;
  logic signed [RelW-1:0]   rx, ry;
  logic signed [ProdW-1:0]  p1_d, p2_d;
  logic signed [CoordW-1:0] minx, maxx, miny, maxy;
  logic signed [PtW-1:0]    pxq, pyq;
  logic                     in_box, hit, past_end;

  function automatic logic signed [ScanW-1:0] trunc_q(input logic signed [CoordW-1:0] q);
    logic signed [CoordW-1:0] s;
    s = q >>> CoordFracBits;
    if (q[CoordW-1] && (q[CoordFracBits-1:0] != '0)) s = s + 1'b1;
    return ScanW'(s);
  endfunction

  always_comb begin
    case (e_q)
      2'd0:    begin xi = cx_q[0]; yi = cy_q[0]; xj = cx_q[1]; yj = cy_q[1]; end
      2'd1:    begin xi = cx_q[1]; yi = cy_q[1]; xj = cx_q[2]; yj = cy_q[2]; end
      default: begin xi = cx_q[2]; yi = cy_q[2]; xj = cx_q[0]; yj = cy_q[0]; end
    endcase
  end

  assign pxq = PtW'(sx_q) <<< CoordFracBits;
  assign pyq = PtW'(sy_q) <<< CoordFracBits;
  assign ptx = start_mode_q ? PtW'(cx_q[2]) : pxq;
  assign pty = start_mode_q ? PtW'(cy_q[2]) : pyq;
  assign dx  = DiffW'(xj) - DiffW'(xi);
  assign dy  = DiffW'(yj) - DiffW'(yi);
  assign rx  = RelW'(ptx) - RelW'(xi);
  assign ry  = RelW'(pty) - RelW'(yi);
  assign p1_d = ProdW'(dx) * ProdW'(ry);
  assign p2_d = ProdW'(dy) * ProdW'(rx);

  always_comb begin
    minx = cx_q[0]; maxx = cx_q[0]; miny = cy_q[0]; maxy = cy_q[0];
    if (cx_q[1] < minx) minx = cx_q[1];
    if (cx_q[2] < minx) minx = cx_q[2];
    if (cx_q[1] > maxx) maxx = cx_q[1];
    if (cx_q[2] > maxx) maxx = cx_q[2];
    if (cy_q[1] < miny) miny = cy_q[1];
    if (cy_q[2] < miny) miny = cy_q[2];
    if (cy_q[1] > maxy) maxy = cy_q[1];
    if (cy_q[2] > maxy) maxy = cy_q[2];
  end

  assign in_box   = pxq <= PtW'(bmaxx_q);
  assign hit      = in_box && (edge_q[0] <= 0) && (edge_q[1] <= 0) && (edge_q[2] <= 0);
  assign past_end = pyq > PtW'(bmaxy_q);

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    job_o   = '0;
    job_o.px    = 12'(sx_q);
    job_o.py    = 12'(sy_q);
    job_o.w0    = EdgeW'(-edge_q[1]);
    job_o.w1    = EdgeW'(-edge_q[2]);
    job_o.w2    = EdgeW'(-edge_q[0]);
    job_o.den   = EdgeW'(-area_q);
    job_o.light = light_q;
    job_o.rgb0  = crgb_q[0];
    job_o.rgb1  = crgb_q[1];
    job_o.rgb2  = crgb_q[2];
    job_o.kind  = KIND_PIXEL;
    case (state_q)
      F_IDLE: begin
        if (accept_i) begin
          if (in_i.op == OP_START) begin
            state_d = F_MUL;
          end else if (in_i.op == OP_STEP && active_q) begin
            if (past_end) begin
              push_o     = 1'b1;
              job_o.kind = KIND_DONE;
            end else begin
              state_d = F_MUL;
            end
          end
        end
      end
      F_MUL: state_d = F_ACC;
      F_ACC: state_d = (start_mode_q || e_q == 2'd2) ? F_CHK : F_MUL;
      F_CHK: begin
        state_d = F_IDLE;
        if (start_mode_q) begin
          push_o     = 1'b1;
          job_o.kind = (edge_q[0] >= 0) ? KIND_REJECT : KIND_ACCEPT;
        end else if (hit) begin
          push_o = 1'b1;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      light_q      <= '0;
      area_q       <= '0;
      bminx_q      <= '0;
      bmaxx_q      <= '0;
      bmaxy_q      <= '0;
      sx_q         <= '0;
      sy_q         <= '0;
      row_in_q     <= 1'b0;
      active_q     <= 1'b0;
      start_mode_q <= 1'b0;
      e_q          <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        F_IDLE: begin
          e_q <= '0;
          if (accept_i && in_i.op == OP_START) begin
            light_q      <= in_i.light;
            start_mode_q <= 1'b1;
          end else if (accept_i && in_i.op == OP_STEP && active_q) begin
            start_mode_q <= 1'b0;
            if (past_end) active_q <= 1'b0;
          end
        end
        F_ACC: if (!start_mode_q) e_q <= e_q + 1'b1;
        F_CHK: begin
          if (start_mode_q) begin
            area_q <= edge_q[0];
            if (edge_q[0] >= 0) begin
              active_q <= 1'b0;
            end else begin
              active_q <= 1'b1;
              bminx_q  <= minx;
              bmaxx_q  <= maxx;
              bmaxy_q  <= maxy;
              sx_q     <= trunc_q(minx);
              sy_q     <= trunc_q(miny);
              row_in_q <= 1'b0;
            end
          end else if (hit) begin
            row_in_q <= 1'b1;
            sx_q     <= sx_q + 1'b1;
          end else if (!row_in_q && in_box) begin
            sx_q <= sx_q + 1'b1;
          end else begin
            sy_q     <= sy_q + 1'b1;
            sx_q     <= trunc_q(bminx_q);
            row_in_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // vertices and edge datapath carry no reset
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && accept_i && in_i.op == OP_LOAD && !active_q &&
        in_i.vertex_index != 2'd3) begin
      cx_q[in_i.vertex_index]   <= in_i.vertex_x;
      cy_q[in_i.vertex_index]   <= in_i.vertex_y;
      crgb_q[in_i.vertex_index] <= {in_i.vertex_red, in_i.vertex_green, in_i.vertex_blue};
    end
    if (state_q == F_MUL) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
    if (state_q == F_ACC) begin
      edge_q[e_q] <= EdgeW'(p1_q) - EdgeW'(p2_q);
    end
  end

  assign idle_o = (state_q == F_IDLE);

endmodule

// ===== rtl/ter_back.sv =====
// ----------------------------------------------------------------------------
// ter_back
// Shades pixel jobs: barycentric blend times light, one quotient bit a cycle,
// and drives the result register, which other job kinds reach unshaded.
// ----------------------------------------------------------------------------
module ter_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  ter_pkg::job_t job_i,
  output logic          pop_o,
  output logic          res_valid_o,
  output ter_pkg::res_t res_o
);
  import ter_pkg::*;

  back_state_e          state_q, state_d;
  job_t                 job_q;
  logic [1:0]           ch_q;
  logic [4:0]           k_q;
  logic [SumW-1:0]      n_q;
  logic [ScaledW-1:0]   rem_q;
  logic [DivW-1:0]      dsh_q;
  logic [QuotW-1:0]     quo_q;
  logic [7:0]           col_q [3];
  logic                 rv_q;
  res_t                 res_q;

  logic [7:0]           c0, c1, c2;
  logic [SumW-1:0]      n_d;
  logic                 ge;
  logic [QuotW-1:0]     quo_d;
  logic [7:0]           sat;

  always_comb begin
    case (ch_q)
      2'd0:    begin c0 = job_q.rgb0[23:16]; c1 = job_q.rgb1[23:16]; c2 = job_q.rgb2[23:16]; end
      2'd1:    begin c0 = job_q.rgb0[15:8];  c1 = job_q.rgb1[15:8];  c2 = job_q.rgb2[15:8];  end
      default: begin c0 = job_q.rgb0[7:0];   c1 = job_q.rgb1[7:0];   c2 = job_q.rgb2[7:0];   end
    endcase
  end

  assign n_d = SumW'(c0) * SumW'(job_q.w0) + SumW'(c1) * SumW'(job_q.w1)
             + SumW'(c2) * SumW'(job_q.w2);
  assign ge    = rem_q >= ScaledW'(dsh_q);
  assign quo_d = {quo_q[QuotW-2:0], ge};
  assign sat   = quo_d[QuotW-1] ? 8'hFF : quo_d[15:8];

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (job_i.kind == KIND_PIXEL) state_d = B_SUM;
        end
      end
      B_SUM:   state_d = B_SCALE;
      B_SCALE: state_d = B_DIV;
      B_DIV: begin
        if (k_q == '0) state_d = (ch_q == 2'd2) ? B_IDLE : B_SUM;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      rv_q    <= 1'b0;
      ch_q    <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= 1'b0;
      case (state_q)
        B_IDLE: begin
          ch_q <= '0;
          if (!empty_i && job_i.kind != KIND_PIXEL) rv_q <= 1'b1;
        end
        B_SCALE: k_q <= 5'(QuotW - 1);
        B_DIV: begin
          k_q <= k_q - 1'b1;
          if (k_q == '0) begin
            ch_q <= ch_q + 1'b1;
            if (ch_q == 2'd2) rv_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        job_q <= job_i;
        if (!empty_i && job_i.kind != KIND_PIXEL) begin
          res_q <= '{kind: job_i.kind, default: '0};
        end
      end
      B_SUM: n_q <= n_d;
      B_SCALE: begin
        rem_q <= n_q * ScaledW'(job_q.light);
        dsh_q <= DivW'(job_q.den) << (QuotW - 1);
        quo_q <= '0;
      end
      B_DIV: begin
        if (ge) rem_q <= rem_q - ScaledW'(dsh_q);
        dsh_q <= dsh_q >> 1;
        quo_q <= quo_d;
        if (k_q == '0) begin
          col_q[ch_q] <= sat;
          if (ch_q == 2'd2) begin
            res_q.kind  <= KIND_PIXEL;
            res_q.px    <= job_q.px;
            res_q.py    <= job_q.py;
            res_q.red   <= col_q[0];
            res_q.green <= col_q[1];
            res_q.blue  <= sat;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/triangle_edge_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer
// Edge-function triangle scan with Gouraud colour and a light factor.
// ----------------------------------------------------------------------------
// Load: no result. Start: a multiply, an accumulate and a check in the front end.
// Step: past the last row it pushes a done word, else each edge function in turn
// by a multiply and an accumulate, then the test. A pixel adds three channels of
// shading in the back end, one quotient bit a cycle, overlapped with the next
// steps through a two-word queue; busy is high while the front end works or
// the queue is full. Reset clears control state; vertices stay undefined.
module triangle_edge_rasterizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ter_pkg::in_t  in_i,
  output logic          res_valid_o,
  output ter_pkg::res_t res_o
);
  import ter_pkg::*;

  logic      accept, front_idle, push, pop;
  job_t      push_job, pop_job;
  q_status_t q_status;

  assign accept = start && !busy;
  assign busy   = !front_idle || q_status.full;

  ter_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .idle_o   (front_idle),
    .push_o   (push),
    .job_o    (push_job)
  );

  ter_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .status_o    (q_status)
  );

  ter_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_status.empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/ter_checker.sv =====
// ----------------------------------------------------------------------------
// ter_checker
// Port-level checks for the triangle edge rasterizer.
// ----------------------------------------------------------------------------
module ter_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  ter_pkg::in_t  in_i,
  input  logic          res_valid_o,
  input  ter_pkg::res_t res_o
);
  import ter_pkg::*;

  // non-pixel words carry zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind != KIND_PIXEL |->
      res_o.px == '0 && res_o.py == '0 && res_o.red == '0 &&
      res_o.green == '0 && res_o.blue == '0)
    else $error("non-pixel result with payload");

  // a load never makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.op == OP_LOAD |=> !busy)
    else $error("busy after load");

  // busy only rises right after an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without a word");

  // a start puts the front end to work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.op == OP_START |=> busy)
    else $error("start not taken");

endmodule

bind triangle_edge_rasterizer ter_checker u_ter_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .in_i        (in_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
